[rtl/core/rft_pkg.sv]
`default_nettype none
package rft_pkg;
   localparam int          CHANNELS_DEF    = 3;
   localparam int          WINDOW          = 16;
   localparam logic [31:0] INIT_PERIOD_RST = 32'd1250000;
   localparam logic [14:0] THRESHOLD_RST   = 15'd150;
   localparam logic [15:0] WEAK_FREQUENCY  = 16'd500;
   localparam logic [33:0] FREQ_NUMERATOR  = 34'd10000000000;
   localparam logic [0:0]  CSR_INIT_PERIOD = 1'b0;
   localparam logic [0:0]  CSR_THRESHOLD   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SUM, ST_RMS_DIV, ST_RMS_DONE, ST_OFF_DIV, ST_CROSS,
      ST_MUL, ST_FREQ_DIV, ST_FINISH, ST_OUT
   } state_type;

   // divider operation select
   typedef enum logic [1:0] { DIV_RMS, DIV_OFF, DIV_FREQ } div_sel_type;

   typedef struct packed {
      logic        load;       // capture input transaction
      logic        sum_step;   // accumulate one square
      logic        div_start;
      div_sel_type div_sel;
      logic        rms_write;
      logic        cross_step; // first crossing or cycle prep
      logic        mul_step;
      logic        finish;     // commit frequency / period
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic valid_ch;
      logic win_full;
      logic is_ch0;
      logic crossing;
      logic phase;
      logic sum_last;
      logic div_busy;
      logic mul_done;
   } status_type;
endpackage
`default_nettype wire

[rtl/core/rft_divider.sv]
`default_nettype none
// Restoring divider, 64 by 64, one quotient bit a cycle.
module rft_divider
   import rft_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             busy,
   output logic [63:0]      quotient
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, den_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) den_ff <= divisor;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/core/rft_datapath.sv]
`default_nettype none
module rft_datapath
   import rft_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic [2:0]  req_channel,
   input  wire logic signed [15:0] req_voltage,
   output logic [30:0]      rsp_channel_rms,
   output logic             rsp_window_done,
   output logic             rsp_cycle_done,
   output logic [15:0]      rsp_frequency,
   output logic [31:0]      rsp_timer_period,
   output logic             rsp_timer_update
);
   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [30:0] sq_mem [CHANNELS*WINDOW];
   logic [3:0]  widx_ff [CHANNELS];
   logic [30:0] rms_ff [CHANNELS];
   logic [31:0] init_ff, period_ff, since_ff, left_ff;
   logic [14:0] thr_ff;
   logic [15:0] freq_ff;
   logic signed [15:0] prev_ff, v_ff;
   logic        phase_ff, ch_ok_ff, wdone_ff, tupd_ff;
   logic        sq_we_ff;
   logic [CW-1:0] ch_ff;
   logic [3:0]  rd_ff;
   logic [30:0] rd_data_ff;
   logic        rd_vld_ff;
   logic [35:0] sum_ff;
   logic [35:0] sum_all;
   logic [31:0] off_ff;
   logic [63:0] prod_ff;
   logic [1:0]  mstep_ff;
   logic [63:0] cycle_ff;
   logic [63:0] div_a, div_b, div_q;
   logic        div_busy;
   logic [15:0] mag;
   logic [31:0] r1;
   logic [CW+3:0] wr_addr, rd_addr;

   assign mag     = v_ff[15] ? 16'(-v_ff) : v_ff;
   assign r1      = (rms_ff[ch_ff] == '0) ? 32'd1 : {1'b0, rms_ff[ch_ff]};
   assign wr_addr = {ch_ff, widx_ff[ch_ff]};
   assign rd_addr = {ch_ff, rd_ff};
   // last square still sits in the read register when the sum closes
   assign sum_all = sum_ff + 36'(rd_data_ff);

   // divider operands
   always_comb begin
      unique case (cmd.div_sel)
         DIV_RMS:  begin div_a = {32'd0, sum_all[35:4]}; div_b = {32'd0, r1}; end
         DIV_OFF:  begin
            div_a = 64'(v_ff[14:0]) * 64'(period_ff);
            div_b = 64'(17'(v_ff) - 17'(prev_ff));
         end
         default:  begin div_a = {30'd0, FREQ_NUMERATOR}; div_b = cycle_ff; end
      endcase
   end

   rft_divider u_div (
      .clock, .reset, .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
      .busy(div_busy), .quotient(div_q)
   );

   // window store: write the square in the cycle after capture
   always_ff @(posedge clock) begin
      if (sq_we_ff && ch_ok_ff) sq_mem[wr_addr] <= 31'(mag) * 31'(mag);
      rd_data_ff <= sq_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      logic [63:0] cyc;
      logic [31:0] per;
      // capture transaction; ch_ok uses the live channel
      if (cmd.load) begin
         v_ff <= req_voltage;
         wdone_ff <= 1'b0;
         tupd_ff  <= 1'b0;
         rd_ff <= '0;
         rd_vld_ff <= 1'b0;
         sum_ff <= '0;
         mstep_ff <= '0;
      end
      if (cmd.sum_step) begin
         if (rd_vld_ff) sum_ff <= sum_ff + 36'(rd_data_ff);
         rd_ff <= rd_ff + 4'd1;
         rd_vld_ff <= 1'b1;
      end
      if (cmd.cross_step) begin
         off_ff <= div_q[31:0];
      end
      if (cmd.mul_step) begin
         // samples * period in two 16x32 halves, then add left_ff and subtract offset
         unique case (mstep_ff)
            2'd0: prod_ff <= 64'(since_ff[15:0]) * 64'(period_ff);
            2'd1: prod_ff <= prod_ff + ((64'(since_ff[31:16]) * 64'(period_ff)) << 16);
            default: begin
               cyc = prod_ff + 64'(left_ff);
               cycle_ff <= (cyc >= 64'(off_ff)) ? cyc - 64'(off_ff) : '0;
            end
         endcase
         mstep_ff <= mstep_ff + 2'd1;
      end
      if (cmd.finish) tupd_ff <= 1'b1;
      if (cmd.rms_write) wdone_ff <= 1'b1;
      if (reset) begin
         init_ff   <= INIT_PERIOD_RST;
         thr_ff    <= THRESHOLD_RST;
         period_ff <= INIT_PERIOD_RST;
         freq_ff   <= WEAK_FREQUENCY;
         prev_ff   <= '0;
         phase_ff  <= 1'b0;
         since_ff  <= '0;
         left_ff   <= '0;
         ch_ok_ff  <= 1'b0;
         ch_ff     <= '0;
         sq_we_ff  <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            widx_ff[i] <= '0;
            rms_ff[i]  <= '0;
         end
      end else begin
         sq_we_ff <= cmd.load;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_INIT_PERIOD: init_ff <= csr_write_data;
               default:         thr_ff  <= csr_write_data[14:0];
            endcase
         end
         if (cmd.load) begin
            ch_ok_ff <= (32'(req_channel) < 32'(CHANNELS));
            ch_ff    <= CW'(req_channel);
         end
         if (cmd.rms_write)
            rms_ff[ch_ff] <= 31'((r1 + div_q[31:0]) >> 1);
         if (cmd.cross_step && !phase_ff) begin
            left_ff  <= div_q[31:0];
            phase_ff <= 1'b1;
         end
         if (cmd.finish) begin
            phase_ff <= 1'b0;
            if (rms_ff[0] >= 31'(thr_ff)) begin
               freq_ff <= (cycle_ff == '0 || div_q > 64'hFFFF) ? 16'hFFFF : div_q[15:0];
               per = (cycle_ff[63:4] > 60'hFFFFFFFF) ? 32'hFFFFFFFF : cycle_ff[35:4];
               period_ff <= (per == '0) ? 32'd1 : per;
            end else begin
               freq_ff   <= WEAK_FREQUENCY;
               period_ff <= (init_ff == '0) ? 32'd1 : init_ff;
            end
         end
         if (cmd.out_load && ch_ok_ff) begin
            widx_ff[ch_ff] <= widx_ff[ch_ff] + 4'd1;
            if (ch_ff == '0) begin
               prev_ff <= v_ff;
               // first crossing restarts the count with this sample as one
               if (cmd.cross_step && !phase_ff)
                  since_ff <= 32'd1;
               else if (since_ff != 32'hFFFFFFFF)
                  since_ff <= since_ff + 32'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_channel_rms  <= ch_ok_ff ? rms_ff[ch_ff] : '0;
         rsp_window_done  <= wdone_ff;
         rsp_cycle_done   <= wdone_ff && ch_ff == '0;
         rsp_frequency    <= freq_ff;
         rsp_timer_period <= period_ff;
         rsp_timer_update <= tupd_ff;
      end
   end

   assign status.valid_ch = ch_ok_ff;
   assign status.win_full = widx_ff[ch_ff] == 4'd15;
   assign status.is_ch0   = ch_ff == '0;
   assign status.crossing = prev_ff[15] && !v_ff[15] && v_ff != '0;
   assign status.phase    = phase_ff;
   assign status.sum_last = rd_vld_ff && rd_ff == 4'd0;
   assign status.div_busy = div_busy;
   assign status.mul_done = mstep_ff == 2'd2;
endmodule
`default_nettype wire

[rtl/core/rft_controller.sv]
`default_nettype none
module rft_controller
   import rft_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   input  wire status_type status,
   output cmd_type   cmd
);
   state_type state_ff, state_in;
   logic      rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_RMS;
      rv_in     = rv_ff && !rsp_ready;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!status.valid_ch) state_in = ST_OUT;
            else if (!status.win_full) state_in = status.is_ch0 ? ST_RMS_DONE : ST_OUT;
            else begin
               cmd.sum_step = 1'b1;
               if (status.sum_last) begin
                  cmd.sum_step  = 1'b0;
                  cmd.div_start = 1'b1;
                  state_in = ST_RMS_DIV;
               end
            end
         end
         ST_RMS_DIV: if (!status.div_busy) begin
            cmd.rms_write = 1'b1;
            state_in = status.is_ch0 ? ST_RMS_DONE : ST_OUT;
         end
         ST_RMS_DONE: begin
            if (status.crossing) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_OFF;
               state_in = ST_OFF_DIV;
            end else state_in = ST_OUT;
         end
         ST_OFF_DIV: if (!status.div_busy) state_in = ST_CROSS;
         ST_CROSS: begin
            // first crossing finishes here once the result register is free
            if (status.phase) begin
               cmd.cross_step = 1'b1;
               state_in = ST_MUL;
            end else if (!rv_ff || rsp_ready) begin
               cmd.cross_step = 1'b1;
               cmd.out_load = 1'b1;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (status.mul_done) state_in = ST_FREQ_DIV;
         end
         ST_FREQ_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FREQ;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.div_sel = DIV_FREQ;
            if (!status.div_busy) begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: if (!rv_ff || rsp_ready) begin
            cmd.out_load = 1'b1;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !status.div_busy) else $error("divider busy in idle");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == ST_IDLE) else $error("load outside idle");
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == ST_IDLE) else $error("output without return");
endmodule
`default_nettype wire

[rtl/core/rms_and_frequency_tracker_core.sv]
`default_nettype none
// Channel  Handshake          Payload
// req      req_valid/ready    channel, voltage
// rsp      rsp_valid/ready    channel_rms .. timer_update
// csr      csr_write_enable   csr_index, csr_write_data
// One sample at a time. A full window adds a window sum and RMS divide; a
// crossing on channel zero adds the offset divide, and a later crossing also
// the multiply and frequency divide. Sync reset restores registers; the
// square store is not cleared. A new sample may enter while a result
// waits; the next result then stalls until that one is taken.
module rms_and_frequency_tracker_core
   import rft_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_channel,
   input  wire logic signed [15:0] req_voltage,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [30:0]      rsp_channel_rms,
   output logic             rsp_window_done,
   output logic             rsp_cycle_done,
   output logic [15:0]      rsp_frequency,
   output logic [31:0]      rsp_timer_period,
   output logic             rsp_timer_update,
   input  wire logic        csr_write_enable,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);
   cmd_type    cmd;
   status_type status;

   rft_controller u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   rft_datapath #(.CHANNELS(CHANNELS)) u_dp (
      .clock, .reset, .cmd, .status, .csr_write_enable, .csr_index,
      .csr_write_data, .req_channel, .req_voltage, .rsp_channel_rms,
      .rsp_window_done, .rsp_cycle_done, .rsp_frequency, .rsp_timer_period,
      .rsp_timer_update
   );
endmodule
`default_nettype wire
